/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the frustum culling block.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AFC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afc assertion failed: same-cycle implication");

// next-cycle implication
`define AFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afc assertion failed: next-cycle implication");

`endif

/* src/afc_pkg.sv */
// Types, widths and constants of the frustum culling block.
// Depends on nothing; imported by aabb_frustum_cull.
package afc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int AXES        = 3;
    localparam int ROW_W       = 64;
    localparam int ELEM_W      = 16;
    localparam int PLANE_W     = ELEM_W + 1;
    localparam int PROD_W      = PLANE_W + ELEM_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int ACC_W       = PAIR_W + 1;
    localparam int ADDR_W      = 5;

    typedef logic signed [ELEM_W-1:0]  elem_t;
    typedef logic signed [PLANE_W-1:0] plane_elem_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PAIR_W-1:0]  pair_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [ROW_W-1:0]          row_t;

    typedef enum logic [1:0] {
        REG_ROW_ONE   = 2'd0,
        REG_ROW_TWO   = 2'd1,
        REG_ROW_THREE = 2'd2,
        REG_ROW_FOUR  = 2'd3
    } reg_idx_t;

    localparam row_t ROW_ONE_RST   = 64'h0000_0000_0000_0100;
    localparam row_t ROW_TWO_RST   = 64'h0000_0000_0100_0000;
    localparam row_t ROW_THREE_RST = 64'h0000_0100_0000_0000;
    localparam row_t ROW_FOUR_RST  = 64'h0100_0000_0000_0000;

    // row combined with row four, and whether it is subtracted
    localparam reg_idx_t PLANE_ROW [PLANE_COUNT] = '{
        REG_ROW_ONE, REG_ROW_ONE, REG_ROW_TWO, REG_ROW_TWO, REG_ROW_THREE, REG_ROW_THREE
    };
    localparam logic PLANE_SUB [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    function automatic elem_t row_elem(input row_t row, input logic [1:0] col);
        return elem_t'(row[ELEM_W*col +: ELEM_W]);
    endfunction

endpackage

/* src/aabb_frustum_cull.sv */
// Axis-aligned box versus view-frustum test: four-stage pipeline and APB register file.
// Depends on afc_pkg and assert_macros.svh.
//
// Takes one box word per cycle while in_ready is high and returns one inside_res word per
// box, in order, flagged by out_valid. The stages in order are the input register, 18
// signed 17x16 multipliers, the pairwise adds, then the final add and sign test of all
// six planes. Each stage advances on its own, so a held result does not stop the stages
// behind it from filling. The six planes are rebuilt from the matrix rows every cycle;
// write rows only while no box is in flight.
`include "assert_macros.svh"

module aabb_frustum_cull
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [ROW_W-1:0]      pwdata,
    output logic [ROW_W-1:0]      prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    box_min_x,
    input  logic signed [15:0]    box_min_y,
    input  logic signed [15:0]    box_min_z,
    input  logic signed [15:0]    box_max_x,
    input  logic signed [15:0]    box_max_y,
    input  logic signed [15:0]    box_max_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  inside_res
);

    row_t        row_one_reg, row_two_reg, row_three_reg, row_four_reg;
    reg_idx_t    reg_idx;
    logic        cfg_wr;

    plane_elem_t plane_n_next    [PLANE_COUNT][AXES];
    plane_elem_t plane_d_next    [PLANE_COUNT];
    logic        plane_zero_next [PLANE_COUNT];
    plane_elem_t plane_n_reg     [PLANE_COUNT][AXES];
    plane_elem_t plane_d_reg     [PLANE_COUNT];
    logic        plane_zero_reg  [PLANE_COUNT];

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    elem_t       lo_reg [AXES];
    elem_t       hi_reg [AXES];
    prod_t       prod_next [PLANE_COUNT][AXES];
    prod_t       prod_reg  [PLANE_COUNT][AXES];
    pair_t       pair_a_reg [PLANE_COUNT];
    pair_t       pair_b_reg [PLANE_COUNT];
    logic        inside_next;
    logic        inside_reg;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_one_reg   <= ROW_ONE_RST;
            row_two_reg   <= ROW_TWO_RST;
            row_three_reg <= ROW_THREE_RST;
            row_four_reg  <= ROW_FOUR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ROW_ONE:   row_one_reg   <= pwdata;
                REG_ROW_TWO:   row_two_reg   <= pwdata;
                REG_ROW_THREE: row_three_reg <= pwdata;
                REG_ROW_FOUR:  row_four_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_ONE:   prdata = row_one_reg;
            REG_ROW_TWO:   prdata = row_two_reg;
            REG_ROW_THREE: prdata = row_three_reg;
            REG_ROW_FOUR:  prdata = row_four_reg;
            default:       prdata = '0;
        endcase
    end

    // plane derivation
    always_comb
    begin
        row_t        side;
        plane_elem_t a;
        plane_elem_t b;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            unique case (PLANE_ROW[p])
                REG_ROW_ONE:   side = row_one_reg;
                REG_ROW_TWO:   side = row_two_reg;
                REG_ROW_THREE: side = row_three_reg;
                default:       side = row_four_reg;
            endcase
            plane_zero_next[p] = 1'b1;
            for (int c = 0; c < AXES; c++)
            begin
                a = PLANE_W'(row_elem(row_four_reg, 2'(c)));
                b = PLANE_W'(row_elem(side, 2'(c)));
                plane_n_next[p][c] = PLANE_SUB[p] ? a - b : a + b;
                if (plane_n_next[p][c] != '0)
                    plane_zero_next[p] = 1'b0;
            end
            a = PLANE_W'(row_elem(row_four_reg, 2'd3));
            b = PLANE_W'(row_elem(side, 2'd3));
            plane_d_next[p] = PLANE_SUB[p] ? a - b : a + b;
        end
    end

    always_ff @(posedge clk)
    begin
        plane_n_reg    <= plane_n_next;
        plane_d_reg    <= plane_d_next;
        plane_zero_reg <= plane_zero_next;
    end

    // pipeline flow control
    assign rdy4     = !s4_valid_reg || out_ready;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: capture box
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            lo_reg[0] <= box_min_x;
            lo_reg[1] <= box_min_y;
            lo_reg[2] <= box_min_z;
            hi_reg[0] <= box_max_x;
            hi_reg[1] <= box_max_y;
            hi_reg[2] <= box_max_z;
        end
    end

    // stage 2: pick far corner and multiply
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                prod_next[p][c] = PROD_W'(plane_n_reg[p][c])
                    * PROD_W'(plane_n_reg[p][c][PLANE_W-1] ? lo_reg[c] : hi_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
            prod_reg <= prod_next;
    end

    // stage 3: pairwise adds
    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                pair_a_reg[p] <= PAIR_W'(prod_reg[p][0]) + PAIR_W'(prod_reg[p][1]);
                pair_b_reg[p] <= PAIR_W'(prod_reg[p][2]) + PAIR_W'(plane_d_reg[p]);
            end
        end
    end

    // stage 4: final add and sign test
    always_comb
    begin
        acc_t acc;
        inside_next = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            acc = ACC_W'(pair_a_reg[p]) + ACC_W'(pair_b_reg[p]);
            if (!plane_zero_reg[p] && acc[ACC_W-1])
                inside_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_valid_reg)
            inside_reg <= inside_next;
    end

    assign out_valid  = s4_valid_reg;
    assign inside_res = inside_reg;

    `AFC_ASSERT_IMPLY(a_stall_only_when_full, !in_ready, s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid && !out_ready)
    `AFC_ASSERT_NEXT(a_accept_lands_stage1, in_valid && in_ready, s1_valid_reg)
    `AFC_ASSERT_NEXT(a_no_invented_result, out_valid && out_ready && !s3_valid_reg, !out_valid)

endmodule
